// ----- src/pal_pkg.sv -----
// Shared types and constants for the palette DAC port.
`timescale 1ns / 1ps

package pal_pkg;

    // Width of the value field and the number of codes it can carry.
    localparam int VALUE_W    = 8;
    localparam int VALUE_SPAN = 256;
    localparam int ACTION_W   = 2;
    localparam int TAG_W      = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_WRITE  = 2'd0,
        ACT_SET_READ   = 2'd1,
        ACT_DATA_WRITE = 2'd2,
        ACT_DATA_READ  = 2'd3
    } t_action;

    // Component order within an entry, also the phase of a read or write run.
    typedef enum logic [TAG_W-1:0] {
        TAG_RED   = 2'd0,
        TAG_GREEN = 2'd1,
        TAG_BLUE  = 2'd2
    } t_tag;

    // Controller to datapath commands.
    typedef struct packed {
        logic set_wr;    // load write index, restart write run
        logic set_rd;    // load read index, restart read run
        logic wr_data;   // take one component of a write run
        logic rd_issue;  // read the entry at the read index
        logic out_load;  // move the read entry's component to the output register
    } t_cmd;

endpackage

// ----- src/pal_ctrl.sv -----
// Controller: input and output handshakes and command sequencing.
`timescale 1ns / 1ps

module pal_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_action,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pal_pkg::t_cmd   o_cmd
);
    import pal_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } t_state;

    t_state  r_state;
    logic    r_out_valid;
    logic    w_accept;
    logic    w_out_free;
    t_action w_action;

    assign w_action   = t_action'(i_action);
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.set_wr   = w_accept && (w_action == ACT_SET_WRITE);
        o_cmd.set_rd   = w_accept && (w_action == ACT_SET_READ);
        o_cmd.wr_data  = w_accept && (w_action == ACT_DATA_WRITE);
        o_cmd.rd_issue = w_accept && (w_action == ACT_DATA_READ);
        o_cmd.out_load = (r_state == ST_LOAD) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (w_action == ACT_DATA_READ)) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- src/pal_dp.sv -----
// Datapath: palette memory, index and phase registers, output payload.
`timescale 1ns / 1ps

module pal_dp #(
    parameter int ENTRIES        = 256,
    parameter int COMPONENT_BITS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pal_pkg::t_cmd              i_cmd,
    input  logic [pal_pkg::VALUE_W-1:0] i_value,
    output logic [COMPONENT_BITS-1:0]  o_read_data,
    output logic [pal_pkg::TAG_W-1:0]  o_tag
);
    import pal_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int ENTRY_W = 3 * COMPONENT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Index reduction modulo the table depth, worked out at elaboration.
    logic [IDX_W-1:0] w_mod_tbl [VALUE_SPAN];
    for (genvar gi = 0; gi < VALUE_SPAN; gi++) begin : g_mod
        assign w_mod_tbl[gi] = IDX_W'(gi % ENTRIES);
    end

    logic [ENTRY_W-1:0]        r_palette [ENTRIES];
    logic [ENTRIES-1:0]        r_valid;
    logic [IDX_W-1:0]          r_wr_ptr;
    logic [IDX_W-1:0]          r_rd_ptr;
    t_tag                      r_wr_phase;
    t_tag                      r_rd_phase;
    logic [COMPONENT_BITS-1:0] r_pend_red;
    logic [COMPONENT_BITS-1:0] r_pend_green;
    logic [ENTRY_W-1:0]        r_q;
    logic                      r_q_vld;
    t_tag                      r_q_tag;
    logic [COMPONENT_BITS-1:0] r_read_data;
    t_tag                      r_tag;

    logic [IDX_W-1:0]          w_idx;
    logic [COMPONENT_BITS-1:0] w_comp;
    logic [COMPONENT_BITS-1:0] w_slice;

    assign w_idx  = w_mod_tbl[i_value];
    assign w_comp = i_value[COMPONENT_BITS-1:0];

    // Palette storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_data && (r_wr_phase == TAG_BLUE)) begin
            r_palette[r_wr_ptr] <= {r_pend_red, r_pend_green, w_comp};
        end
        if (i_cmd.rd_issue) begin
            r_q <= r_palette[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_wr_phase   <= TAG_RED;
            r_rd_phase   <= TAG_RED;
            r_pend_red   <= '0;
            r_pend_green <= '0;
        end else begin
            if (i_cmd.set_wr) begin
                r_wr_ptr     <= w_idx;
                r_wr_phase   <= TAG_RED;
                r_pend_red   <= '0;
                r_pend_green <= '0;
            end else if (i_cmd.wr_data) begin
                case (r_wr_phase)
                    TAG_RED: begin
                        r_pend_red   <= w_comp;
                        r_pend_green <= '0;
                        r_wr_phase   <= TAG_GREEN;
                    end
                    TAG_GREEN: begin
                        r_pend_green <= w_comp;
                        r_wr_phase   <= TAG_BLUE;
                    end
                    default: begin
                        r_valid[r_wr_ptr] <= 1'b1;
                        r_wr_ptr     <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
                        r_wr_phase   <= TAG_RED;
                        r_pend_red   <= '0;
                        r_pend_green <= '0;
                    end
                endcase
            end

            if (i_cmd.set_rd) begin
                r_rd_ptr   <= w_idx;
                r_rd_phase <= TAG_RED;
            end else if (i_cmd.rd_issue) begin
                case (r_rd_phase)
                    TAG_RED:   r_rd_phase <= TAG_GREEN;
                    TAG_GREEN: r_rd_phase <= TAG_BLUE;
                    default: begin
                        r_rd_phase <= TAG_RED;
                        r_rd_ptr   <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
                    end
                endcase
            end
        end
    end

    // Read-side payload: valid bit and phase travel with the memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_q_vld <= r_valid[r_rd_ptr];
            r_q_tag <= r_rd_phase;
        end
        if (i_cmd.out_load) begin
            r_read_data <= r_q_vld ? w_slice : '0;
            r_tag       <= r_q_tag;
        end
    end

    always_comb begin
        case (r_q_tag)
            TAG_RED:   w_slice = r_q[ENTRY_W-1 -: COMPONENT_BITS];
            TAG_GREEN: w_slice = r_q[2*COMPONENT_BITS-1 -: COMPONENT_BITS];
            default:   w_slice = r_q[COMPONENT_BITS-1:0];
        endcase
    end

    assign o_read_data = r_read_data;
    assign o_tag       = r_tag;

endmodule

// ----- src/palette_dac_port.sv -----
// Top level of the palette DAC port: colour lookup table with auto-increment access.
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)          tuser (low bit up)
// s_axis    in         value[7:0]                  action[1:0]
// m_axis    out        read_data, zero padding     component_tag[1:0]
//
// Index loads and data writes leave the controller idle, so the next beat is taken in
// the following cycle. A data read goes through the registered palette memory read
// port first, then the chosen component moves to the output register.
// The output register holds a result while m_axis_tready is low. Index loads
// and data writes go on meanwhile; a later read waits in the load state, with
// s_axis_tready low, until that register frees up.
// Reset (synchronous, active low) clears indices, phases and the per-entry
// valid bits, so every entry reads as zero until written; no clearing pass.

module palette_dac_port #(
    parameter int ENTRIES        = 256,
    parameter int COMPONENT_BITS = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // value[7:0]
    input  logic [1:0]                       s_axis_tuser,   // action[1:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_data[COMPONENT_BITS-1:0], zeros above
    output logic [((COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic [1:0]                       m_axis_tuser    // component_tag[1:0]
);
    import pal_pkg::*;

    localparam int OUT_W = ((COMPONENT_BITS + 7) / 8) * 8;

    t_cmd                      w_cmd;
    logic [COMPONENT_BITS-1:0] w_read_data;
    logic [TAG_W-1:0]          w_tag;

    // Handshakes and command sequencing.
    pal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    // Palette memory, pointers and output payload.
    pal_dp #(
        .ENTRIES        (ENTRIES),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (s_axis_tdata),
        .o_read_data (w_read_data),
        .o_tag       (w_tag)
    );

    // Zero-pad the component up to a whole byte.
    assign m_axis_tdata = OUT_W'(w_read_data);
    assign m_axis_tuser = w_tag;

endmodule
